// ----- hw/rtl/rc_frame_receive_decode_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the frame decoder checker.
// Both expect signals named clk and rst in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef RC_FRAME_RECEIVE_DECODE_DEFINES_SVH
`define RC_FRAME_RECEIVE_DECODE_DEFINES_SVH

// Same-cycle implication check
`define RCD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check
`define RCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rcd_pkg.sv -----
// ---------------------------------------------------------------------------
// rcd_pkg
// Shared constants and types for the remote-control frame decoder.
// ---------------------------------------------------------------------------
package rcd_pkg;

  // Frame geometry and byte counter
  localparam int BUFFER_BYTES = 36;
  localparam int FRAME_BYTES  = 18;
  localparam int COUNT_W      = $clog2(BUFFER_BYTES + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(BUFFER_BYTES);
  localparam logic [COUNT_W-1:0] COUNT_FRAME = COUNT_W'(FRAME_BYTES);

  // Channel offset register
  localparam int                 CH_W           = 11;
  localparam logic [CH_W-1:0]    OFFSET_DEFAULT = 11'h400;

  // Input beat kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_IDLE = 1'b1;

  // Frame bytes, index 0 is the first byte received
  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  // Decoded result
  typedef struct packed {
    logic signed [CH_W:0] channel_0;
    logic signed [CH_W:0] channel_1;
    logic signed [CH_W:0] channel_2;
    logic signed [CH_W:0] channel_3;
    logic signed [CH_W:0] channel_4;
    logic        [3:0]    switches;
    logic signed [15:0]   mouse_x;
    logic signed [15:0]   mouse_y;
    logic signed [15:0]   mouse_z;
    logic        [7:0]    press_left;
    logic        [7:0]    press_right;
    logic        [15:0]   key_bits;
  } result_t;

endpackage

// ----- hw/rtl/rcd_byte_cell.sv -----
// ---------------------------------------------------------------------------
// rcd_byte_cell
// One byte of the frame shift line: loads its neighbor's byte on a shift.
// ---------------------------------------------------------------------------
module rcd_byte_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] d,
  output logic [7:0] q
);

  // Payload only, no reset needed
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ----- hw/rtl/rcd_frame_unpack.sv -----
// ---------------------------------------------------------------------------
// rcd_frame_unpack
// Splits an 18-byte frame into stick channels, switches, mouse and keys.
// ---------------------------------------------------------------------------
module rcd_frame_unpack (
  input  rcd_pkg::frame_t              frame,
  input  logic [rcd_pkg::CH_W-1:0]     offset,
  output rcd_pkg::result_t             res
);

  logic [rcd_pkg::CH_W-1:0] raw0, raw1, raw2, raw3, raw4;

  // Packed 11-bit channels, little endian bit stream
  assign raw0 = {frame[1][2:0], frame[0]};
  assign raw1 = {frame[2][5:0], frame[1][7:3]};
  assign raw2 = {frame[4][0],   frame[3], frame[2][7:6]};
  assign raw3 = {frame[5][3:0], frame[4][7:1]};
  assign raw4 = {frame[17][2:0], frame[16]};

  // Centering: 11-bit minus 11-bit always fits 12-bit two's complement
  assign res.channel_0 = {1'b0, raw0} - {1'b0, offset};
  assign res.channel_1 = {1'b0, raw1} - {1'b0, offset};
  assign res.channel_2 = {1'b0, raw2} - {1'b0, offset};
  assign res.channel_3 = {1'b0, raw3} - {1'b0, offset};
  assign res.channel_4 = {1'b0, raw4} - {1'b0, offset};

  // Switches and raw fields
  assign res.switches    = frame[5][7:4];
  assign res.mouse_x     = {frame[7],  frame[6]};
  assign res.mouse_y     = {frame[9],  frame[8]};
  assign res.mouse_z     = {frame[11], frame[10]};
  assign res.press_left  = frame[12];
  assign res.press_right = frame[13];
  assign res.key_bits    = {frame[15], frame[14]};

endmodule

// ----- hw/rtl/rc_frame_receive_decode.sv -----
// ---------------------------------------------------------------------------
// rc_frame_receive_decode
// Remote-control frame receiver: bytes shift into a row of byte cells; an
// idle beat after exactly 18 bytes decodes the frame into one result beat.
// ---------------------------------------------------------------------------
// Throughput: one input beat (byte or idle) per cycle while not stalled, set by the byte cell
//   shift line, which moves every cell in the same cycle as an accepted byte beat below 18 bytes.
// Latency: a result beat is valid the cycle after its idle beat.
// Input stalls only while a result waits and the output is stalled.
// Reset: clears byte count and output valid, offset returns to 1024;
//   the frame cells are not cleared.
module rc_frame_receive_decode (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration
  input  logic                          cfg_write,
  input  logic [rcd_pkg::CH_W-1:0]      cfg_data,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [7:0]                    rx_byte,
  // Output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [rcd_pkg::CH_W:0] channel_0,
  output logic signed [rcd_pkg::CH_W:0] channel_1,
  output logic signed [rcd_pkg::CH_W:0] channel_2,
  output logic signed [rcd_pkg::CH_W:0] channel_3,
  output logic signed [rcd_pkg::CH_W:0] channel_4,
  output logic [3:0]                    switches,
  output logic signed [15:0]            mouse_x,
  output logic signed [15:0]            mouse_y,
  output logic signed [15:0]            mouse_z,
  output logic [7:0]                    press_left,
  output logic [7:0]                    press_right,
  output logic [15:0]                   key_bits
);

  logic [rcd_pkg::CH_W-1:0]    offset;
  logic [rcd_pkg::COUNT_W-1:0] count;
  logic                        in_beat;
  logic                        byte_beat;
  logic                        idle_beat;
  logic                        shift;
  logic                        load;
  rcd_pkg::frame_t             frame;
  rcd_pkg::result_t            dec;
  rcd_pkg::result_t            res;

  // Handshake decode
  assign in_stall  = out_valid & out_stall;
  assign in_beat   = in_valid & ~in_stall;
  assign byte_beat = in_beat & (mode == rcd_pkg::MODE_BYTE);
  assign idle_beat = in_beat & (mode == rcd_pkg::MODE_IDLE);
  assign shift     = byte_beat & (count < rcd_pkg::COUNT_FRAME);
  assign load      = idle_beat & (count == rcd_pkg::COUNT_FRAME);

  // Offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= rcd_pkg::OFFSET_DEFAULT;
    end else if (cfg_write) begin
      offset <= cfg_data;
    end
  end

  // Byte counter, saturating; idle clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (idle_beat) begin
      count <= '0;
    end else if (byte_beat && (count < rcd_pkg::COUNT_MAX)) begin
      count <= count + rcd_pkg::COUNT_W'(1);
    end
  end

  // Shift line: new byte enters the last cell, oldest sits in cell 0
  for (genvar k = 0; k < rcd_pkg::FRAME_BYTES; k++) begin : g_cell
    logic [7:0] d;
    if (k == rcd_pkg::FRAME_BYTES - 1) begin : g_tail
      assign d = rx_byte;
    end else begin : g_link
      assign d = frame[k+1];
    end
    rcd_byte_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     (d),
      .q     (frame[k])
    );
  end

  // Field decode
  rcd_frame_unpack u_unpack (
    .frame  (frame),
    .offset (offset),
    .res    (dec)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= dec;
    end
  end

  assign channel_0   = res.channel_0;
  assign channel_1   = res.channel_1;
  assign channel_2   = res.channel_2;
  assign channel_3   = res.channel_3;
  assign channel_4   = res.channel_4;
  assign switches    = res.switches;
  assign mouse_x     = res.mouse_x;
  assign mouse_y     = res.mouse_y;
  assign mouse_z     = res.mouse_z;
  assign press_left  = res.press_left;
  assign press_right = res.press_right;
  assign key_bits    = res.key_bits;

endmodule

// ----- hw/rtl/rcd_checker.sv -----
// ---------------------------------------------------------------------------
// rcd_checker
// Port-level checks for the frame decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "rc_frame_receive_decode_defines.svh"

module rcd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          mode,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [15:0]                   key_bits
);

  // Result beat held while stalled
  `RCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(key_bits), "result dropped or changed under stall")

  // Input only stalls behind a waiting result
  `RCD_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with no result waiting")

  // A data byte never produces a result
  `RCD_ASSERT_NEXT(a_byte_no_result, in_valid && !in_stall && !mode && !(out_valid && out_stall), !out_valid, "result after a data byte")

  // A new result follows an accepted idle beat
  `RCD_ASSERT_SAME(a_result_source, $rose(out_valid), $past(in_valid && !in_stall && mode), "result without idle beat")

endmodule

bind rc_frame_receive_decode rcd_checker u_rcd_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the remote-control frame decoder. A queue of
// byte and idle beats feeds a clocked driver. Each accepted beat updates a
// local copy of the frame store and byte count. An idle beat after exactly
// 18 bytes adds the expected decoded frame to a queue. A clocked monitor
// checks each result beat field by field against that queue. The channel
// offset is rewritten between phases while the decoder is idle. Each side
// idles at random, and once the output holds off long enough to back up
// the input.
// ---------------------------------------------------------------------------
module tb_top;
  import rcd_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } rx_beat_t;

  localparam int CYCLE_LIMIT  = 250000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BEATS  = 150;
  localparam int NUM_PHASES   = 6;
  localparam int FILL_RANDOM  = -1;

  // DUT signals, all inputs known from time zero
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CH_W-1:0]        cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic                   mode      = MODE_BYTE;
  logic [7:0]             rx_byte   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [CH_W:0]   channel_0;
  logic signed [CH_W:0]   channel_1;
  logic signed [CH_W:0]   channel_2;
  logic signed [CH_W:0]   channel_3;
  logic signed [CH_W:0]   channel_4;
  logic [3:0]             switches;
  logic signed [15:0]     mouse_x;
  logic signed [15:0]     mouse_y;
  logic signed [15:0]     mouse_z;
  logic [7:0]             press_left;
  logic [7:0]             press_right;
  logic [15:0]            key_bits;

  // Local copy of decoder state
  logic [7:0]             frame_img [FRAME_BYTES];
  int unsigned            rx_count = 0;
  logic [CH_W-1:0]        centre   = OFFSET_DEFAULT;

  rx_beat_t               pending_beats[$];
  result_t                frame_results_due[$];
  rx_beat_t               next_beat;
  result_t                want;

  // Traffic shaping
  bit                     gappy_in     = 1'b0;
  bit                     gappy_out    = 1'b0;
  bit                     hold_request = 1'b0;
  bit                     hold_done    = 1'b0;
  int unsigned            send_gap     = 0;
  int unsigned            stall_left   = 0;
  int unsigned            hold_left    = 0;

  // Run statistics
  int unsigned            cycle_count     = 0;
  int unsigned            beats_queued    = 0;
  int unsigned            beats_taken     = 0;
  int unsigned            frames_decoded  = 0;
  int unsigned            idles_no_frame  = 0;
  int unsigned            frames_checked  = 0;
  int unsigned            in_stall_cycles = 0;
  int unsigned            mismatches      = 0;

  rc_frame_receive_decode u_top (.*);

  always #2 clk = ~clk;

  // Gap length: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Channel value minus the current centre offset, 12-bit two's complement
  function automatic logic signed [CH_W:0] centred(input logic [CH_W-1:0] raw);
    return $signed({1'b0, raw} - {1'b0, centre});
  endfunction

  // Advance local state by one accepted beat; queue a result on a full frame
  task automatic absorb_beat(input rx_beat_t b);
    result_t r;
    if (b.kind == MODE_BYTE) begin
      if (rx_count < FRAME_BYTES) frame_img[rx_count] = b.data;
      if (rx_count < BUFFER_BYTES) rx_count++;
    end else begin
      if (rx_count == FRAME_BYTES) begin
        r.channel_0   = centred({frame_img[1][2:0], frame_img[0]});
        r.channel_1   = centred({frame_img[2][5:0], frame_img[1][7:3]});
        r.channel_2   = centred({frame_img[4][0], frame_img[3], frame_img[2][7:6]});
        r.channel_3   = centred({frame_img[5][3:0], frame_img[4][7:1]});
        r.channel_4   = centred({frame_img[17][2:0], frame_img[16]});
        r.switches    = frame_img[5][7:4];
        r.mouse_x     = {frame_img[7], frame_img[6]};
        r.mouse_y     = {frame_img[9], frame_img[8]};
        r.mouse_z     = {frame_img[11], frame_img[10]};
        r.press_left  = frame_img[12];
        r.press_right = frame_img[13];
        r.key_bits    = {frame_img[15], frame_img[14]};
        frame_results_due.push_back(r);
        frames_decoded++;
      end else begin
        idles_no_frame++;
      end
      rx_count = 0;
    end
  endtask

  task automatic queue_bytes(input int n, input int fill);
    rx_beat_t b;
    for (int i = 0; i < n; i++) begin
      b.kind = MODE_BYTE;
      b.data = (fill == FILL_RANDOM) ? 8'($urandom) : 8'(fill);
      pending_beats.push_back(b);
      beats_queued++;
    end
  endtask

  task automatic queue_idle();
    rx_beat_t b;
    b.kind = MODE_IDLE;
    b.data = 8'($urandom);
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // One random sequence: mostly clean frames, some runts, overruns and noise
  task automatic queue_sequence();
    int unsigned pick;
    int unsigned style;
    int          fill;
    pick  = $urandom_range(0, 99);
    style = $urandom_range(0, 9);
    fill  = (style == 0) ? 8'h00 : (style == 1) ? 8'hff : FILL_RANDOM;
    if (pick < 75) begin
      queue_bytes(FRAME_BYTES, fill);
      queue_idle();
    end else if (pick < 85) begin
      queue_bytes($urandom_range(0, FRAME_BYTES - 1), fill);
      queue_idle();
    end else if (pick < 95) begin
      queue_bytes($urandom_range(FRAME_BYTES + 1, BUFFER_BYTES + 9), fill);
      queue_idle();
    end else if (pick < 98) begin
      queue_bytes($urandom_range(1, 5), FILL_RANDOM);
    end else begin
      queue_idle();
    end
  endtask

  // Wait until every queued beat is taken and every result has come back
  task automatic drain();
    while (pending_beats.size() != 0 || in_valid || frame_results_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Input driver: payload holds while stalled, a random gap may follow each beat
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_beat(rx_beat_t'({mode, rx_byte}));
        beats_taken++;
      end
      if (in_valid && in_stall) begin
        in_stall_cycles++;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        next_beat = pending_beats.pop_front();
        in_valid <= 1'b1;
        mode     <= next_beat.kind;
        rx_byte  <= next_beat.data;
        send_gap = gappy_in ? idle_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = gappy_out ? idle_len() : 0;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (frame_results_due.size() == 0) begin
        $error("result beat with no decoded frame pending");
        mismatches++;
      end else begin
        want = frame_results_due.pop_front();
        check_field("channel_0",   want.channel_0,   channel_0);
        check_field("channel_1",   want.channel_1,   channel_1);
        check_field("channel_2",   want.channel_2,   channel_2);
        check_field("channel_3",   want.channel_3,   channel_3);
        check_field("channel_4",   want.channel_4,   channel_4);
        check_field("switches",    want.switches,    switches);
        check_field("mouse_x",     want.mouse_x,     mouse_x);
        check_field("mouse_y",     want.mouse_y,     mouse_y);
        check_field("mouse_z",     want.mouse_z,     mouse_z);
        check_field("press_left",  want.press_left,  press_left);
        check_field("press_right", want.press_right, press_right);
        check_field("key_bits",    want.key_bits,    key_bits);
        frames_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, frame_results_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus and phase control
  initial begin
    logic [CH_W-1:0] phase_offset;
    int unsigned     start_count;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty idle, all-ones frame at reset offset, short frame
    queue_idle();
    queue_bytes(FRAME_BYTES, 8'hff);
    queue_idle();
    queue_bytes(2, 8'h00);
    queue_idle();
    // Second short zero frame right behind the first
    queue_bytes(2, 8'h00);
    queue_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      repeat (4) @(posedge clk);

      // Offset extremes first, then random, then back to the default
      case (ph)
        0:       phase_offset = '0;
        1:       phase_offset = '1;
        5:       phase_offset = OFFSET_DEFAULT;
        default: phase_offset = CH_W'($urandom);
      endcase
      cfg_write <= 1'b1;
      cfg_data  <= phase_offset;
      centre    = phase_offset;
      @(posedge clk);
      cfg_write <= 1'b0;

      // Phase 1 runs flat out; phase 2 holds the output off against a busy sender
      gappy_in  = (ph != 1) && (ph != 2);
      gappy_out = (ph != 1) && (ph != 2);
      if (ph == 2) hold_request = 1'b1;

      if (ph == 0) begin
        queue_bytes(BUFFER_BYTES + 4, FILL_RANDOM);
        queue_idle();
        queue_bytes(FRAME_BYTES, 8'h00);
        queue_idle();
      end

      start_count = beats_queued;
      while (beats_queued - start_count < PHASE_BEATS) queue_sequence();
    end

    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d beats, %0d frames decoded and checked, %0d idles ending no frame",
             beats_taken, frames_checked, idles_no_frame);
    $display("Offsets 0, 2047, default and random; input held off for %0d cycles",
             in_stall_cycles);
    if (mismatches == 0 && frame_results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
